// File: rtl/bandwidth_vote_aggregator_unit_defines.svh
// Assertion macros for the bandwidth vote aggregator checker.
// Depends on nothing; the user supplies clock and reset in scope.
`ifndef BANDWIDTH_VOTE_AGGREGATOR_UNIT_DEFINES_SVH
`define BANDWIDTH_VOTE_AGGREGATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BVAU_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bvau assertion failed");

// next-cycle implication
`define BVAU_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bvau assertion failed");

`endif

// File: rtl/bvau_pkg.sv
// Shared types and constants of the bandwidth vote aggregator.
// Used by every RTL module of the block.
package bvau_pkg;

   localparam int NUM_BUCKETS = 3;
   localparam int BW_W   = 32;
   localparam int ACC_W  = 48;
   localparam int PROD_W = 64;
   localparam int STEP_W = 4;
   localparam int BKT_W  = 2;
   localparam int REQ_DATA_W = 208;
   localparam int RSP_DATA_W = 96;
   localparam int CSR_IDX_W  = 3;

   localparam logic [ACC_W-1:0] KEEPALIVE_VOTE = ACC_W'(16000);
   localparam logic [ACC_W-1:0] SAT_MAX = {ACC_W{1'b1}};

   localparam logic [STEP_W-1:0] STEP_NODE_END = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_FIN_END  = STEP_W'(11);
   localparam logic [BKT_W-1:0]  BKT_SLEEP     = BKT_W'(2);

   // request tdata offsets
   localparam int OFF_PERF = 6 * BW_W;
   localparam int OFF_BUS  = OFF_PERF + 3;
   localparam int OFF_CHAN = OFF_BUS + 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BCM_WIDTH   = 3'd0,
      CSR_VOTE_UNIT   = 3'd1,
      CSR_VOTE_SCALE  = 3'd2,
      CSR_ENABLE_MASK = 3'd3,
      CSR_PERF_MASK   = 3'd4,
      CSR_KEEPALIVE   = 3'd5,
      CSR_INIT_PHASE  = 3'd6
   } csr_index_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MUL   = 7'b0000010,
      ST_START = 7'b0000100,
      ST_WAIT  = 7'b0001000,
      ST_FIN   = 7'b0010000,
      ST_EMIT  = 7'b0100000,
      ST_SPARE = 7'b1000000
   } state_type;

   typedef struct packed {
      logic              load;
      logic              mul;
      logic              start;
      logic              store;
      logic              fin;
      logic [STEP_W-1:0] step;
      logic [BKT_W-1:0]  bucket;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic last_node;
   } status_type;

endpackage

// File: rtl/bandwidth_vote_aggregator_unit.sv
// Top level of the bandwidth vote aggregator: controller plus datapath.
// Depends on bvau_pkg, bvau_ctrl, bvau_datapath, bvau_divider.
//
//  channel  direction  handshake          payload
//  req      in         tvalid/tready      tdata node fields, tlast last_node
//  rsp      out        tvalid/tready      tdata votes, tuser bucket, tlast end
//  csr      in         we                 index, wdata
//
// Each node takes six multiply/divide steps on the shared divider (48
// quotient bits); a last node adds six more steps, a vote-rules state
// and three result transactions.
// Synchronous active-high reset; no clearing pass. rsp stalls hold the block.
module bandwidth_vote_aggregator_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: avg_active, avg_wake, avg_sleep, peak_active, peak_wake,
   //        peak_sleep, perf_active, perf_wake, perf_sleep, bus_bytes,
   //        channel_count, zero pad
   input  logic [bvau_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: vote_avg, vote_peak
   output logic [bvau_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: bucket_index
   output logic [bvau_pkg::BKT_W-1:0]        rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [bvau_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_wdata
);
   import bvau_pkg::*;

   cmd_type    cmd;
   status_type status;

   bvau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bvau_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

   assign rsp_tuser = cmd.bucket;
   assign rsp_tlast = cmd.bucket == BKT_SLEEP;

endmodule

// File: rtl/bvau_divider.sv
// Iterative restoring divider, one quotient bit per cycle, with round-up of
// small nonzero quotients to one and pass-through on a zero divisor.
module bvau_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bvau_pkg::ACC_W-1:0]  num,
   input  logic [bvau_pkg::BW_W-1:0]   den,
   output logic                        done,
   output logic [bvau_pkg::ACC_W-1:0]  quo
);
   import bvau_pkg::*;

   logic [ACC_W-1:0] num_ff, quo_ff, quo_in;
   logic [BW_W-1:0]  den_ff, rem_ff, rem_in;
   logic [5:0]       cnt_ff;
   logic             busy_ff, done_ff;
   logic [BW_W:0]    trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[ACC_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in = fits ? BW_W'(trial - {1'b0, den_ff}) : trial[BW_W-1:0];
      quo_in = {quo_ff[ACC_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= den != '0;
         done_ff <= den == '0;
      end else if (busy_ff) begin
         done_ff <= cnt_ff == '0;
         busy_ff <= cnt_ff != '0;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         quo_ff <= num;
         rem_ff <= '0;
         cnt_ff <= 6'(ACC_W - 1);
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - 6'd1;
      end
   end

   assign done = done_ff;
   assign quo  = (quo_ff == '0 && num_ff != '0) ? ACC_W'(1) : quo_ff;

endmodule

// File: rtl/bvau_datapath.sv
// Datapath: configuration registers, item registers, shared multiplier,
// divider, accumulators and final vote registers. Uses bvau_pkg, bvau_divider.
module bvau_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bvau_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_wdata,
   input  logic [bvau_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   input  bvau_pkg::cmd_type                 cmd,
   output bvau_pkg::status_type              status,
   output logic [bvau_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import bvau_pkg::*;

   logic [15:0] bcm_width_ff, vote_scale_ff;
   logic [31:0] vote_unit_ff, enable_mask_ff, perf_mask_ff;
   logic        keepalive_ff, init_phase_ff;

   logic [BW_W-1:0]  avg_ff [NUM_BUCKETS];
   logic [BW_W-1:0]  peak_ff [NUM_BUCKETS];
   logic [7:0]       bus_ff;
   logic [3:0]       chan_ff;
   logic             last_ff;

   logic [ACC_W-1:0] avg_max_ff [NUM_BUCKETS];
   logic [ACC_W-1:0] peak_max_ff [NUM_BUCKETS];
   logic [NUM_BUCKETS-1:0] perf_ff;
   logic [ACC_W-1:0] vx_ff [NUM_BUCKETS];
   logic [ACC_W-1:0] vy_ff [NUM_BUCKETS];
   logic [ACC_W-1:0] vx_in [NUM_BUCKETS];
   logic [ACC_W-1:0] vy_in [NUM_BUCKETS];

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [ACC_W-1:0]  mul_a, div_num, quo;
   logic [15:0]       mul_b;
   logic [BW_W-1:0]   div_den;
   logic              div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         bcm_width_ff   <= 16'd4;
         vote_unit_ff   <= 32'd1000;
         vote_scale_ff  <= 16'd1;
         enable_mask_ff <= '0;
         perf_mask_ff   <= '0;
         keepalive_ff   <= 1'b0;
         init_phase_ff  <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BCM_WIDTH:   bcm_width_ff   <= csr_wdata[15:0];
            CSR_VOTE_UNIT:   vote_unit_ff   <= csr_wdata;
            CSR_VOTE_SCALE:  vote_scale_ff  <= csr_wdata[15:0];
            CSR_ENABLE_MASK: enable_mask_ff <= csr_wdata;
            CSR_PERF_MASK:   perf_mask_ff   <= csr_wdata;
            CSR_KEEPALIVE:   keepalive_ff   <= csr_wdata[0];
            CSR_INIT_PHASE:  init_phase_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            avg_ff[b]  <= req_tdata[b*BW_W +: BW_W];
            peak_ff[b] <= req_tdata[(b+3)*BW_W +: BW_W];
         end
         bus_ff  <= req_tdata[OFF_BUS +: 8];
         chan_ff <= req_tdata[OFF_CHAN +: 4];
         last_ff <= req_tlast;
      end
   end

   // operand selection per step
   always_comb begin
      mul_a   = '0;
      mul_b   = bcm_width_ff;
      div_den = vote_unit_ff;
      case (cmd.step)
         4'd0, 4'd1, 4'd2: begin
            mul_a   = ACC_W'(avg_ff[cmd.step[1:0]]);
            div_den = BW_W'({4'b0, bus_ff} * {8'b0, chan_ff});
         end
         4'd3: begin mul_a = ACC_W'(peak_ff[0]); div_den = BW_W'(bus_ff); end
         4'd4: begin mul_a = ACC_W'(peak_ff[1]); div_den = BW_W'(bus_ff); end
         4'd5: begin mul_a = ACC_W'(peak_ff[2]); div_den = BW_W'(bus_ff); end
         4'd6: begin mul_a = avg_max_ff[0]; mul_b = vote_scale_ff; end
         4'd7: begin mul_a = avg_max_ff[1]; mul_b = vote_scale_ff; end
         4'd8: begin mul_a = avg_max_ff[2]; mul_b = vote_scale_ff; end
         4'd9: begin mul_a = peak_max_ff[0]; mul_b = vote_scale_ff; end
         4'd10: begin mul_a = peak_max_ff[1]; mul_b = vote_scale_ff; end
         4'd11: begin mul_a = peak_max_ff[2]; mul_b = vote_scale_ff; end
         default: ;
      endcase
   end

   assign prod_in = {16'b0, mul_a} * {48'b0, mul_b};
   assign div_num = (prod_ff[PROD_W-1:ACC_W] != '0) ? SAT_MAX : prod_ff[ACC_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mul) prod_ff <= prod_in;
   end

   bvau_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (quo)
   );

   // override and keepalive
   always_comb begin
      for (int b = 0; b < NUM_BUCKETS; b++) begin
         vx_in[b] = vx_ff[b];
         vy_in[b] = vy_ff[b];
         if (enable_mask_ff != '0 && (vx_ff[b] != '0 || vy_ff[b] != '0)) begin
            vx_in[b] = '0;
            vy_in[b] = ACC_W'(enable_mask_ff | (perf_ff[b] ? perf_mask_ff : 32'b0));
         end
      end
      if (keepalive_ff) begin
         if (init_phase_ff) begin
            for (int b = 0; b < NUM_BUCKETS; b++) begin
               vx_in[b] = KEEPALIVE_VOTE;
               vy_in[b] = KEEPALIVE_VOTE;
            end
         end else if (vx_in[0] == '0 && vy_in[0] == '0) begin
            vx_in[0] = ACC_W'(1);
            vy_in[0] = ACC_W'(1);
            vx_in[1] = ACC_W'(1);
            vy_in[1] = ACC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         perf_ff <= '0;
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            avg_max_ff[b]  <= '0;
            peak_max_ff[b] <= '0;
         end
      end else if (cmd.fin) begin
         perf_ff <= '0;
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            avg_max_ff[b]  <= '0;
            peak_max_ff[b] <= '0;
         end
      end else if (cmd.load) begin
         perf_ff <= perf_ff | req_tdata[OFF_PERF +: NUM_BUCKETS];
      end else if (cmd.store) begin
         case (cmd.step)
            4'd0, 4'd1, 4'd2:
               if (quo > avg_max_ff[cmd.step[1:0]]) avg_max_ff[cmd.step[1:0]] <= quo;
            4'd3: if (quo > peak_max_ff[0]) peak_max_ff[0] <= quo;
            4'd4: if (quo > peak_max_ff[1]) peak_max_ff[1] <= quo;
            4'd5: if (quo > peak_max_ff[2]) peak_max_ff[2] <= quo;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            vx_ff[b] <= vx_in[b];
            vy_ff[b] <= vy_in[b];
         end
      end else if (cmd.store) begin
         case (cmd.step)
            4'd6:  vx_ff[0] <= quo;
            4'd7:  vx_ff[1] <= quo;
            4'd8:  vx_ff[2] <= quo;
            4'd9:  vy_ff[0] <= quo;
            4'd10: vy_ff[1] <= quo;
            4'd11: vy_ff[2] <= quo;
            default: ;
         endcase
      end
   end

   assign status.div_done  = div_done;
   assign status.last_node = last_ff;

   always_comb begin
      case (cmd.bucket)
         2'd0:    rsp_tdata = {vy_ff[0], vx_ff[0]};
         2'd1:    rsp_tdata = {vy_ff[1], vx_ff[1]};
         default: rsp_tdata = {vy_ff[2], vx_ff[2]};
      endcase
   end

endmodule

// File: rtl/bvau_ctrl.sv
// Controller state machine: sequences multiply, divide and store steps,
// then the final votes and the three result transactions. Uses bvau_pkg.
module bvau_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  bvau_pkg::status_type  status,
   output bvau_pkg::cmd_type     cmd
);
   import bvau_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [BKT_W-1:0]  bkt_ff, bkt_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      bkt_in   = bkt_ff;
      cmd       = '0;
      cmd.step   = step_ff;
      cmd.bucket = bkt_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_START;
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.div_done) begin
               cmd.store = 1'b1;
               step_in   = step_ff + STEP_W'(1);
               if (step_ff == STEP_FIN_END) begin
                  state_in = ST_FIN;
               end else if (step_ff == STEP_NODE_END && !status.last_node) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            bkt_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               bkt_in = bkt_ff + BKT_W'(1);
               if (bkt_ff == BKT_SLEEP) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         bkt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         bkt_ff   <= bkt_in;
      end
   end

endmodule

// File: rtl/bvau_checker.sv
// Port-level checker for the bandwidth vote aggregator, bound to the top.
// Depends on bandwidth_vote_aggregator_unit_defines.svh and bvau_pkg.
`include "bandwidth_vote_aggregator_unit_defines.svh"

module bvau_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [bvau_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [bvau_pkg::BKT_W-1:0]        rsp_tuser,
   input logic                              rsp_tlast
);
   import bvau_pkg::*;

   `BVAU_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `BVAU_ASSERT_IMP(a_last_sleep, rsp_tvalid, rsp_tlast == (rsp_tuser == BKT_SLEEP))
   `BVAU_ASSERT_IMP(a_no_overlap, rsp_tvalid, !req_tready)
   `BVAU_ASSERT_NXT(a_bucket_step, rsp_tvalid && rsp_tready && !rsp_tlast,
                    rsp_tvalid && rsp_tuser == $past(rsp_tuser) + 2'd1)

endmodule

bind bandwidth_vote_aggregator_unit bvau_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
